// ===== rtl/core/mlqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mlqd_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int NUM_LEVELS_DEF = 4;

	localparam int ID_W = 16;
	localparam int TIME_W = 16;
	localparam int PRIO_W = 3;
	localparam int QUANTUM_W = 8;
	localparam int SLVL_W = 2;
	localparam int DELTA_W = 17;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 72;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd1;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_BAD_PRIO   = 3'd1,
		ST_FULL       = 3'd2,
		ST_DISPATCHED = 3'd3,
		ST_EMPTY      = 3'd4
	} status_t;

	// Command as classified by the front end.
	typedef struct packed {
		logic              dispatch;
		logic              bad_prio;
		logic [PRIO_W-1:0] prio;
		logic [ID_W-1:0]   proc_id;
		logic [TIME_W-1:0] arrival;
	} cmd_t;

	typedef struct packed {
		status_t                   status;
		logic [ID_W-1:0]           served_id;
		logic [SLVL_W-1:0]         served_level;
		logic [TIME_W-1:0]         finish_time;
		logic signed [DELTA_W-1:0] turnaround;
		logic signed [DELTA_W-1:0] wait_time;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlqd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mlqd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlqd_front import mlqd_pkg::*; #(
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  wire logic [0:0]            s_axis_tuser,
	input  wire logic                  s_axis_tlast,
	output logic                       cmd_valid,
	output cmd_t                       cmd,
	input  wire logic                  cmd_pop
);

	localparam int CMP_W = $clog2(NUM_LEVELS + 1) + PRIO_W;

	logic       push;
	logic [1:0] fill_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	cmd_t       slot_q [2];
	cmd_t       cls;

	// The batch marker carries no meaning for scheduling.
	always_comb begin
		cls.dispatch = s_axis_tuser[0];
		cls.proc_id = s_axis_tdata[15:0];
		cls.prio = s_axis_tdata[18:16];
		cls.arrival = s_axis_tdata[34:19];
		cls.bad_prio = (CMP_W'(cls.prio) >= CMP_W'(NUM_LEVELS)) && !s_axis_tlast
			|| (CMP_W'(cls.prio) >= CMP_W'(NUM_LEVELS));
	end

	assign s_axis_tready = (fill_q != 2'd2);
	assign push = s_axis_tvalid && s_axis_tready;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mlqd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlqd_back import mlqd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [QUANTUM_W-1:0]   cfg_data,
	input  wire logic                   cmd_valid,
	input  wire cmd_t                   cmd,
	output logic                        cmd_pop,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic      [2:0]             m_axis_tuser
);

	localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = LVL_W + PTR_W;
	localparam int RAM_DEPTH = NUM_LEVELS << PTR_W;
	localparam int EXT_W = LVL_W + PRIO_W;
	localparam int ENTRY_W = ID_W + TIME_W;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_READ = 2'b10
	} bk_state_t;

	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		ptr_adv = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	bk_state_t             state_q;
	logic [PTR_W-1:0]      head_q [NUM_LEVELS];
	logic [PTR_W-1:0]      tail_q [NUM_LEVELS];
	logic [CNT_W-1:0]      cnt_q [NUM_LEVELS];
	logic [LVL_W-1:0]      next_lvl_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [QUANTUM_W-1:0]  quantum_q;
	logic [LVL_W-1:0]      pend_lvl_q;
	logic [TIME_W-1:0]     finish_q;
	logic                  out_valid_q;
	res_t                  out_res_q;

	logic [EXT_W-1:0]      prio_ext;
	logic [LVL_W-1:0]      add_lvl;
	logic [NUM_LEVELS-1:0] nonempty;
	logic                  found;
	logic [LVL_W-1:0]      sel_lvl;
	logic                  full;
	logic                  add_ok;
	logic                  deq;
	logic [TIME_W-1:0]     finish_nxt;
	logic [ENTRY_W-1:0]    rd_entry;
	logic [LVL_W+1:0]      lvl_ext;
	logic [DELTA_W-1:0]    turn;
	res_t                  imm_res;
	res_t                  rd_res;

	assign cfg_ready = 1'b1;

	assign prio_ext = EXT_W'(cmd.prio);
	assign add_lvl = prio_ext[LVL_W-1:0];

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			nonempty[i] = (cnt_q[i] != '0);
		end
	end

	// Cyclic search from next_lvl_q; the descending loop lets the nearest level win.
	always_comb begin
		logic [LVL_W:0] idx;
		found = 1'b0;
		sel_lvl = '0;
		for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
			idx = {1'b0, next_lvl_q} + (LVL_W + 1)'(k);
			if (idx >= (LVL_W + 1)'(NUM_LEVELS)) begin
				idx = idx - (LVL_W + 1)'(NUM_LEVELS);
			end
			if (nonempty[idx[LVL_W-1:0]]) begin
				found = 1'b1;
				sel_lvl = idx[LVL_W-1:0];
			end
		end
	end

	assign cmd_pop = (state_q == BK_IDLE) && cmd_valid && (!out_valid_q || m_axis_tready);
	assign full = (cnt_q[add_lvl] == CNT_W'(QUEUE_DEPTH));
	assign add_ok = cmd_pop && !cmd.dispatch && !cmd.bad_prio && !full;
	assign deq = cmd_pop && cmd.dispatch && found;
	assign finish_nxt = elapsed_q + TIME_W'(quantum_q);

	mlqd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (add_ok),
		.wr_addr(ADDR_W'({add_lvl, tail_q[add_lvl]})),
		.wr_data({cmd.proc_id, cmd.arrival}),
		.rd_en  (deq),
		.rd_addr(ADDR_W'({sel_lvl, head_q[sel_lvl]})),
		.rd_data(rd_entry)
	);

	always_comb begin
		imm_res = '0;
		priority if (cmd.dispatch) begin
			imm_res.status = ST_EMPTY;
		end else if (cmd.bad_prio) begin
			imm_res.status = ST_BAD_PRIO;
		end else if (full) begin
			imm_res.status = ST_FULL;
		end else begin
			imm_res.status = ST_ADDED;
		end
	end

	assign lvl_ext = (LVL_W + 2)'(pend_lvl_q);
	assign turn = {1'b0, finish_q} - {1'b0, rd_entry[TIME_W-1:0]};

	always_comb begin
		rd_res.status = ST_DISPATCHED;
		rd_res.served_id = rd_entry[ENTRY_W-1:TIME_W];
		rd_res.served_level = lvl_ext[SLVL_W-1:0];
		rd_res.finish_time = finish_q;
		rd_res.turnaround = turn;
		rd_res.wait_time = turn - DELTA_W'(quantum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			next_lvl_q <= '0;
			elapsed_q <= '0;
			quantum_q <= QUANTUM_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				quantum_q <= cfg_data;
			end
			if (add_ok) begin
				tail_q[add_lvl] <= ptr_adv(tail_q[add_lvl]);
				cnt_q[add_lvl] <= cnt_q[add_lvl] + 1'b1;
			end
			if (deq) begin
				head_q[sel_lvl] <= ptr_adv(head_q[sel_lvl]);
				cnt_q[sel_lvl] <= cnt_q[sel_lvl] - 1'b1;
				next_lvl_q <= (sel_lvl == LVL_W'(NUM_LEVELS - 1)) ? '0 : sel_lvl + 1'b1;
				elapsed_q <= finish_nxt;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (deq) begin
						state_q <= BK_READ;
					end
				end
				BK_READ: begin
					state_q <= BK_IDLE;
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			// The output slot is known to be free in BK_READ, since the pop required it.
			if ((cmd_pop && !deq) || state_q == BK_READ) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			pend_lvl_q <= sel_lvl;
			finish_q <= finish_nxt;
		end
		if (cmd_pop && !deq) begin
			out_res_q <= imm_res;
		end else if (state_q == BK_READ) begin
			out_res_q <= rd_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_res_q.status;
	assign m_axis_tdata = {4'b0, out_res_q.wait_time, out_res_q.turnaround,
		out_res_q.finish_time, out_res_q.served_level, out_res_q.served_id};

endmodule

`default_nettype wire

// ===== rtl/core/multi_level_queue_dispatcher_core.sv =====
// An add, a rejected add or a dispatch that finds every queue empty passes through the
// command queue and the result register; a served dispatch also passes through the
// registered read of the queue memory (state BK_READ). Throughput: one add per cycle while
// results are taken; a served dispatch holds the back end in BK_READ. A two-entry command queue decouples input.
// Reset (arst_n low, asynchronous) empties all levels, clears time and next level, and sets
// the quantum to 1; queue memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_level_queue_dispatcher_core import mlqd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [QUANTUM_W-1:0]   cfg_data,       // quantum
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// proc_id[15:0], priority_req[18:16], arrival_time[34:19], zero pad[39:35]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [0:0]             s_axis_tuser,   // opcode[0]
	input  wire logic                   s_axis_tlast,   // batch_last
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// served_id[15:0], served_level[17:16], finish_time[33:18], turnaround[50:34],
	// wait_time[67:51], zero pad[71:68]
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic      [2:0]             m_axis_tuser    // status[2:0]
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	mlqd_front #(
		.NUM_LEVELS(NUM_LEVELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	mlqd_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.NUM_LEVELS (NUM_LEVELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

`ifndef SYNTHESIS
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("back end took a command that the front end did not offer");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !$past(m_axis_tvalid)) |-> ($past(cmd_pop) || $past(cmd_pop, 2)))
		else $error("result appeared without a command taken one or two cycles before");

	a_nondispatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_DISPATCHED) |-> (m_axis_tdata == '0))
		else $error("result of an add or empty dispatch carries nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== tb/mlqd_dispatch_checker.sv =====
`timescale 1ns / 1ps

module mlqd_dispatch_checker import mlqd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [QUANTUM_W-1:0]   cfg_data,       // quantum
	input  wire logic                   s_axis_tvalid,
	input  wire logic                   s_axis_tready,
	// proc_id[15:0], priority_req[18:16], arrival_time[34:19], zero pad[39:35]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [0:0]             s_axis_tuser,   // opcode[0]
	input  wire logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// served_id[15:0], served_level[17:16], finish_time[33:18], turnaround[50:34],
	// wait_time[67:51], zero pad[71:68]
	input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic [2:0]             m_axis_tuser,   // status[2:0]
	output int                          errors,
	output int                          pending
);

	localparam int SLOTS = NUM_LEVELS_DEF * QUEUE_DEPTH_DEF;

	// Shadow copy of the per-level process queues: id in the high half, arrival low.
	logic [31:0]          slot_mem [SLOTS];
	int                   head_idx [NUM_LEVELS_DEF];
	int                   tail_idx [NUM_LEVELS_DEF];
	int                   fill     [NUM_LEVELS_DEF];
	int                   rr_level;
	logic [TIME_W-1:0]    clock_now;
	logic [QUANTUM_W-1:0] quantum;
	res_t                 expected_results [$];
	int                   accepted_cmds;
	int                   accepted_results;

	assign pending = accepted_cmds - accepted_results;

	function automatic res_t schedule_cmd(cmd_t cmd);
		res_t        r;
		int          p;
		int          lvl;
		bit          served;
		logic [31:0] entry;
		r = '0;
		served = 1'b0;
		p = int'(cmd.prio);
		if (!cmd.dispatch) begin
			if (cmd.bad_prio) begin
				r.status = ST_BAD_PRIO;
			end else if (fill[p] >= QUEUE_DEPTH_DEF) begin
				r.status = ST_FULL;
			end else begin
				slot_mem[p * QUEUE_DEPTH_DEF + tail_idx[p]] = {cmd.proc_id, cmd.arrival};
				tail_idx[p] = (tail_idx[p] + 1) % QUEUE_DEPTH_DEF;
				fill[p]++;
				r.status = ST_ADDED;
			end
		end else begin
			r.status = ST_EMPTY;
			// Search levels cyclically, starting after the one served last.
			for (int k = 0; k < NUM_LEVELS_DEF; k++) begin
				lvl = (rr_level + k) % NUM_LEVELS_DEF;
				if (!served && fill[lvl] != 0) begin
					served = 1'b1;
					entry = slot_mem[lvl * QUEUE_DEPTH_DEF + head_idx[lvl]];
					head_idx[lvl] = (head_idx[lvl] + 1) % QUEUE_DEPTH_DEF;
					fill[lvl]--;
					rr_level = (lvl + 1) % NUM_LEVELS_DEF;
					clock_now = clock_now + quantum;
					r.status = ST_DISPATCHED;
					r.served_id = entry[31:16];
					r.served_level = lvl[SLVL_W-1:0];
					r.finish_time = clock_now;
					r.turnaround = {1'b0, clock_now} - {1'b0, entry[15:0]};
					r.wait_time = r.turnaround - {9'd0, quantum};
				end
			end
		end
		return r;
	endfunction

	function automatic int field_diff(string name, logic [DELTA_W-1:0] want_v,
			logic [DELTA_W-1:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		cmd_t cmd;
		res_t want;
		res_t got;
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS_DEF; l++) begin
				head_idx[l] = 0;
				tail_idx[l] = 0;
				fill[l] = 0;
			end
			rr_level = 0;
			clock_now = '0;
			quantum = QUANTUM_RST;
			expected_results.delete();
			accepted_cmds <= 0;
			accepted_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				quantum = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				accepted_results <= accepted_results + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual status %0d tdata %h",
						$time, m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					got.status = status_t'(m_axis_tuser);
					got.served_id = m_axis_tdata[15:0];
					got.served_level = m_axis_tdata[17:16];
					got.finish_time = m_axis_tdata[33:18];
					got.turnaround = m_axis_tdata[50:34];
					got.wait_time = m_axis_tdata[67:51];
					errors += field_diff("status", want.status, got.status);
					errors += field_diff("served_id", want.served_id, got.served_id);
					errors += field_diff("served_level", want.served_level, got.served_level);
					errors += field_diff("finish_time", want.finish_time, got.finish_time);
					errors += field_diff("turnaround", want.turnaround, got.turnaround);
					errors += field_diff("wait_time", want.wait_time, got.wait_time);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cmd.dispatch = s_axis_tuser[0];
				cmd.proc_id = s_axis_tdata[15:0];
				cmd.prio = s_axis_tdata[18:16];
				cmd.arrival = s_axis_tdata[34:19];
				cmd.bad_prio = (cmd.prio >= NUM_LEVELS_DEF);
				expected_results.push_back(schedule_cmd(cmd));
				accepted_cmds <= accepted_cmds + 1;
			end
		end
	end

endmodule

// ===== tb/multi_level_queue_dispatcher_core_tb.sv =====
`timescale 1ns / 1ps

module multi_level_queue_dispatcher_core_tb;
	import mlqd_pkg::*;

	localparam bit OP_ADD      = 1'b0;
	localparam bit OP_DISPATCH = 1'b1;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_CMDS = 1750;
	localparam int NUM_PHASES  = 5;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [QUANTUM_W-1:0]   cfg_data;       // quantum
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// proc_id[15:0], priority_req[18:16], arrival_time[34:19], zero pad[39:35]
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]             s_axis_tuser;   // opcode[0]
	logic                   s_axis_tlast;   // batch_last
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// served_id[15:0], served_level[17:16], finish_time[33:18], turnaround[50:34],
	// wait_time[67:51], zero pad[71:68]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]             m_axis_tuser;   // status[2:0]
	int                     errors;
	int                     pending;
	int                     idle_cycles;
	bit                     steady;         // no gaps on either side while set

	multi_level_queue_dispatcher_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	mlqd_dispatch_checker i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is declared hung once no transfer of any kind has happened for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [PRIO_W-1:0] pick_prio();
		if ($urandom_range(0, 99) < 12) return PRIO_W'($urandom_range(NUM_LEVELS_DEF, 7));
		return PRIO_W'($urandom_range(0, NUM_LEVELS_DEF - 1));
	endfunction

	initial begin
		int run;
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			repeat (run) @(posedge clk);
			stall = steady ? 0 : gap_len();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Returns at the clock edge at which the command transfer took place.
	task automatic send_request(input bit op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] arrival,
			input bit batch_last);
		int gap;
		gap = steady ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({arrival, prio, id});
		s_axis_tuser <= op;
		s_axis_tlast <= batch_last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic add_proc(input logic [PRIO_W-1:0] prio);
		send_request(OP_ADD, ID_W'($urandom), prio, TIME_W'($urandom), 1'($urandom));
	endtask

	// The id, priority and arrival fields of a dispatch carry random content.
	task automatic dispatch_next();
		send_request(OP_DISPATCH, ID_W'($urandom), PRIO_W'($urandom), TIME_W'($urandom),
			1'($urandom));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
		cfg_valid <= 1'b1;
		cfg_data <= q;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [QUANTUM_W-1:0] phase_quanta [NUM_PHASES];
		int                   sent;
		int                   mode;
		int                   add_pct;
		int                   lvl;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_ADD;
		s_axis_tlast <= 1'b0;
		steady = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the quantum left at its reset value.
		dispatch_next();
		send_request(OP_ADD, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1);
		send_request(OP_ADD, 16'h0000, 3'd4, 16'h0000, 1'b0);
		send_request(OP_ADD, 16'h0000, 3'd0, 16'hFFFF, 1'b0);
		send_request(OP_ADD, 16'hFFFF, 3'd3, 16'h0000, 1'b1);
		send_request(OP_ADD, 16'h1234, 3'd1, 16'h8000, 1'b0);
		send_request(OP_ADD, 16'hA5A5, 3'd2, 16'h0001, 1'b0);
		send_request(OP_ADD, 16'h5A5A, 3'd0, 16'h0002, 1'b1);
		send_request(OP_ADD, 16'h0F0F, 3'd2, 16'h7FFF, 1'b0);
		// Late arrivals against an early finish give negative turnaround and wait.
		repeat (7) dispatch_next();
		dispatch_next();
		send_request(OP_ADD, 16'h8001, 3'd1, 16'h0000, 1'b1);
		dispatch_next();
		dispatch_next();
		wait_idle();

		phase_quanta[0] = 8'd255;
		phase_quanta[1] = 8'd0;
		phase_quanta[2] = QUANTUM_W'($urandom_range(2, 254));
		phase_quanta[3] = 8'd1;
		phase_quanta[4] = QUANTUM_W'($urandom_range(2, 254));
		sent = 0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_quantum(phase_quanta[ph]);
			while (sent < (ph + 1) * RANDOM_CMDS / NUM_PHASES) begin
				steady = ($urandom_range(0, 4) == 0);
				mode = $urandom_range(0, 11);
				if (mode == 0) begin
					// Overfill one level so that the last adds bounce off a full queue.
					lvl = $urandom_range(0, NUM_LEVELS_DEF - 1);
					repeat ($urandom_range(130, 140)) begin
						add_proc(PRIO_W'(lvl));
						sent++;
					end
				end else begin
					add_pct = (mode <= 4) ? 85 : (mode <= 8) ? 10 : 50;
					repeat ($urandom_range(10, 50)) begin
						if ($urandom_range(0, 99) < add_pct) begin
							add_proc(pick_prio());
						end else begin
							dispatch_next();
						end
						sent++;
					end
				end
			end
			steady = 1'b0;
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== multi_level_queue_dispatcher_core.f =====
rtl/core/mlqd_pkg.sv
rtl/core/mlqd_ram.sv
rtl/core/mlqd_front.sv
rtl/core/mlqd_back.sv
rtl/core/multi_level_queue_dispatcher_core.sv
tb/mlqd_dispatch_checker.sv
tb/multi_level_queue_dispatcher_core_tb.sv
